@@ src/tagged_pad_frame_receiver_defines.svh @@
// Assertion macros for the checker file of the tagged pad frame receiver.
// Expects signals named clk_i and rst_ni in the scope where the macros are used.
`ifndef TAGGED_PAD_FRAME_RECEIVER_DEFINES_SVH
`define TAGGED_PAD_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpfr assertion failed");

// Next-cycle implication, checked out of reset.
`define TPFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpfr assertion failed");

`endif

@@ src/tpfr_pkg.sv @@
// Package for the tagged pad frame receiver: payload structs, codes and pad decode.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tpfr_pkg;

  // Timer counters and tick limit registers
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned NumSlots   = 4;
  localparam int unsigned SlotWidth  = $clog2(NumSlots);
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // Largest timer count, held in 32 bits for limit clamping
  localparam logic [31:0] TimerMaxWide = 32'((64'd1 << TimerWidth) - 64'd1);

  // Slot contents after reset, slot 0 in the low byte
  localparam logic [NumSlots-1:0][7:0] SlotReset = {8'hc0, 8'h8f, 8'h7f, 8'h3f};

  // Config register reset values
  localparam logic [3:0]          AttemptLimitReset = 4'd5;
  localparam logic [CfgWidth-1:0] ByteWaitReset     = CfgWidth'(10);
  localparam logic [CfgWidth-1:0] IdleTimeoutReset  = CfgWidth'(100);

  typedef enum logic [1:0] {
    LS_NORMAL     = 2'd0,
    LS_SUCCESS    = 2'd1,
    LS_INCOMPLETE = 2'd2,
    LS_FAILURE    = 2'd3
  } link_status_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ATTEMPT_LIMIT = 2'd0,
    CFG_BYTE_WAIT     = 2'd1,
    CFG_IDLE_TIMEOUT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_item_t;

  typedef struct packed {
    link_status_e link_status;
    logic         frame_done;
    logic [1:0]   dpad_x_code;
    logic [1:0]   dpad_y_code;
    logic [1:0]   right_stick_x_code;
    logic [1:0]   right_stick_y_code;
    logic [1:0]   left_stick_x_code;
    logic [1:0]   left_stick_y_code;
    logic [3:0]   misc_buttons;
    logic [3:0]   shoulder_buttons;
    logic [3:0]   mark_buttons;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          attempt_limit;
    logic [CfgWidth-1:0] byte_wait_ticks;
    logic [CfgWidth-1:0] idle_timeout_ticks;
  } cfg_t;

  // Tick limit as the counters see it: zero acts as one, larger values clamp
  function automatic logic [TimerWidth-1:0] tick_limit(logic [CfgWidth-1:0] lim);
    logic [31:0] wide;
    wide = 32'(lim);
    if (wide == 32'd0) begin
      wide = 32'd1;
    end
    if (wide > TimerMaxWide) begin
      wide = TimerMaxWide;
    end
    return TimerWidth'(wide);
  endfunction

  // Pad field decode from the four slot bytes; buttons are active low on the wire
  function automatic out_item_t decode_pad(link_status_e status, logic done,
                                           logic [NumSlots-1:0][7:0] s);
    out_item_t r;
    r.link_status        = status;
    r.frame_done         = done;
    r.dpad_x_code        = {s[0][5], s[1][1]};
    r.dpad_y_code        = {s[0][4], s[1][0]};
    r.right_stick_x_code = s[2][5:4];
    r.right_stick_y_code = s[3][1:0];
    r.left_stick_x_code  = s[3][3:2];
    r.left_stick_y_code  = s[3][5:4];
    r.misc_buttons       = ~s[0][3:0];
    r.shoulder_buttons   = ~s[1][5:2];
    r.mark_buttons       = ~s[2][3:0];
    return r;
  endfunction

endpackage

@@ src/tpfr_frame_engine.sv @@
// Frame state of the tagged pad frame receiver: slots, seen mask, attempt and timers.
// Depends on tpfr_pkg. Updates state on each fired item and returns its result.
`timescale 1ns / 1ps

module tpfr_frame_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tpfr_pkg::in_item_t  item_i,
  input  tpfr_pkg::cfg_t      cfg_i,
  output tpfr_pkg::out_item_t result_o
);

  localparam logic [tpfr_pkg::TimerWidth-1:0] TimerMax = '1;

  logic [tpfr_pkg::NumSlots-1:0][7:0]   slot_q, slot_d;
  logic [tpfr_pkg::NumSlots-1:0]        seen_q, seen_d;
  logic [3:0]                           att_q, att_d;
  logic [tpfr_pkg::TimerWidth-1:0]      wait_q, wait_d;
  logic [tpfr_pkg::TimerWidth-1:0]      idle_q, idle_d;
  logic                                 in_frame_q, in_frame_d;
  logic                                 run_q, run_d;
  tpfr_pkg::link_status_e               status_q, status_d;

  logic                                 done;
  logic                                 use_att;
  logic                                 end_frame;
  tpfr_pkg::link_status_e               end_status;
  logic [3:0]                           att_lim;
  logic [tpfr_pkg::TimerWidth-1:0]      wait_lim;
  logic [tpfr_pkg::TimerWidth-1:0]      idle_lim;
  logic [tpfr_pkg::SlotWidth-1:0]       tag;

  // A zero limit behaves as one
  assign att_lim  = (cfg_i.attempt_limit == '0) ? 4'd1 : cfg_i.attempt_limit;
  assign wait_lim = tpfr_pkg::tick_limit(cfg_i.byte_wait_ticks);
  assign idle_lim = tpfr_pkg::tick_limit(cfg_i.idle_timeout_ticks);
  assign tag      = item_i.rx_byte[7:6];

  // Next state for one item
  always_comb begin
    slot_d     = slot_q;
    seen_d     = seen_q;
    att_d      = att_q;
    wait_d     = wait_q;
    idle_d     = idle_q;
    in_frame_d = in_frame_q;
    run_d      = run_q;
    status_d   = status_q;
    use_att    = 1'b0;
    end_frame  = 1'b0;
    end_status = tpfr_pkg::LS_NORMAL;

    if (item_i.action == tpfr_pkg::ACT_BYTE) begin
      // any byte opens a frame, even one flagged with an error
      if (!in_frame_q) begin
        in_frame_d = 1'b1;
        seen_d     = '0;
        att_d      = '0;
        wait_d     = '0;
        run_d      = 1'b0;
        idle_d     = '0;
      end
      if (!item_i.rx_error) begin
        slot_d[tag] = item_i.rx_byte;
        seen_d      = seen_d | (tpfr_pkg::NumSlots'(1) << tag);
        if (&seen_d) begin
          end_frame  = 1'b1;
          end_status = tpfr_pkg::LS_SUCCESS;
        end else begin
          use_att = 1'b1;
        end
      end
    end else if (in_frame_q) begin
      // per-byte wait inside a frame
      if (wait_q != TimerMax) begin
        wait_d = wait_q + tpfr_pkg::TimerWidth'(1);
      end
      if (wait_d >= wait_lim) begin
        use_att = 1'b1;
      end
    end else begin
      // idle timeout; first tick restarts it and clears the status
      if (!run_q) begin
        run_d    = 1'b1;
        idle_d   = '0;
        status_d = tpfr_pkg::LS_NORMAL;
      end
      if (idle_d != TimerMax) begin
        idle_d = idle_d + tpfr_pkg::TimerWidth'(1);
      end
      if (idle_d >= idle_lim) begin
        status_d = tpfr_pkg::LS_FAILURE;
        run_d    = 1'b0;
        idle_d   = '0;
      end
    end

    // one attempt used, saturating at 15
    if (use_att) begin
      if (att_d != 4'hf) begin
        att_d = att_d + 4'd1;
      end
      wait_d = '0;
      if (att_d >= att_lim) begin
        end_frame  = 1'b1;
        end_status = tpfr_pkg::LS_INCOMPLETE;
      end
    end

    // frame end clears everything but the slots and records the end status
    if (end_frame) begin
      status_d   = end_status;
      in_frame_d = 1'b0;
      seen_d     = '0;
      att_d      = '0;
      wait_d     = '0;
      run_d      = 1'b0;
      idle_d     = '0;
    end
    done = end_frame;
  end

  assign result_o = tpfr_pkg::decode_pad(status_d, done, slot_d);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= tpfr_pkg::SlotReset;
      seen_q     <= '0;
      att_q      <= '0;
      wait_q     <= '0;
      idle_q     <= '0;
      in_frame_q <= 1'b0;
      run_q      <= 1'b0;
      status_q   <= tpfr_pkg::LS_NORMAL;
    end else if (fire_i) begin
      slot_q     <= slot_d;
      seen_q     <= seen_d;
      att_q      <= att_d;
      wait_q     <= wait_d;
      idle_q     <= idle_d;
      in_frame_q <= in_frame_d;
      run_q      <= run_d;
      status_q   <= status_d;
    end
  end

endmodule

@@ src/tagged_pad_frame_receiver.sv @@
// Top level of the tagged pad frame receiver: input register, config registers,
// output register. Depends on tpfr_pkg and tpfr_frame_engine.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item per UART byte
//   (action 0, with its error flag) or per time tick (action 1).
//   Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result per
//   item, in order: link status, frame done flag and the decoded pad fields.
//   Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 attempt
//   limit, 1 byte wait ticks, 2 idle timeout ticks); index 3 is ignored. Write
//   only while no item is in flight.
//   Path: an accepted item is held in the input register, then the frame update
//   writes its result into the output register.
//   Throughput: one item per cycle while the output is not stalled; the frame
//   update is a single pass of short logic between the input and output registers.
//   Reset: asynchronous, clears both channel stages, restores the default slot
//   bytes and limits (5 attempts, 10 ticks, 100 ticks), status normal.
//   Stall: a stalled result holds; the input register still takes one more item,
//   after which in_stall_o rises until the result is taken.
module tagged_pad_frame_receiver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tpfr_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tpfr_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [tpfr_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tpfr_pkg::CfgWidth-1:0]        cfg_wdata_i
);

  logic                s1_valid_q;
  tpfr_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  tpfr_pkg::out_item_t out_item_q;
  tpfr_pkg::cfg_t      cfg_q;
  tpfr_pkg::out_item_t result;
  logic                s1_ready;
  logic                s2_ready;
  logic                fire;

  // Handshake between the two stages
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign fire       = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attempt_limit      <= tpfr_pkg::AttemptLimitReset;
      cfg_q.byte_wait_ticks    <= tpfr_pkg::ByteWaitReset;
      cfg_q.idle_timeout_ticks <= tpfr_pkg::IdleTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpfr_pkg::CFG_ATTEMPT_LIMIT: begin
          cfg_q.attempt_limit <= cfg_wdata_i[3:0];
        end
        tpfr_pkg::CFG_BYTE_WAIT: begin
          cfg_q.byte_wait_ticks <= cfg_wdata_i;
        end
        tpfr_pkg::CFG_IDLE_TIMEOUT: begin
          cfg_q.idle_timeout_ticks <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_item_q <= in_item_i;
    end
  end

  // Frame update
  tpfr_frame_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ src/tpfr_checker.sv @@
// Port-level checks for the tagged pad frame receiver, bound to the top level.
// Depends on tpfr_pkg and tagged_pad_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`include "tagged_pad_frame_receiver_defines.svh"

module tpfr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input tpfr_pkg::out_item_t              out_item_o
);

  logic in_accept;
  logic out_done;
  logic done_status_ok;

  assign in_accept      = in_valid_i && !in_stall_o;
  assign out_done       = out_valid_o && out_item_o.frame_done;
  assign done_status_ok = (out_item_o.link_status == tpfr_pkg::LS_SUCCESS) ||
                          (out_item_o.link_status == tpfr_pkg::LS_INCOMPLETE);

  // a stalled result holds
  `TPFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // a finished frame reports success or incomplete, never normal or failure
  `TPFR_ASSERT_IMPL(a_done_status, out_done, done_status_ok)

  // input only backs up when the output is full and stalled
  `TPFR_ASSERT_IMPL(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // a new result appears only after an item was accepted into the input register
  `TPFR_ASSERT_IMPL(a_latency, $rose(out_valid_o), $past(in_accept, 2))

endmodule

bind tagged_pad_frame_receiver tpfr_checker u_tpfr_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for tagged_pad_frame_receiver: directed rows, then random
// UART byte / tick streams checked against a cycle-free frame predictor.
// Depends on tpfr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TimerMax     =
    int'((64'd1 << tpfr_pkg::TimerWidth) - 64'd1);
  localparam logic [1:0]  CfgIdxUnused = 2'd3;
  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned HoldAfter    = 150;

  // One item to offer, with an optional hand-typed expected result
  typedef struct packed {
    tpfr_pkg::in_item_t  item;
    logic                typed;
    tpfr_pkg::out_item_t want;
  } feed_t;

  // Neutral pad decode of the reset slot bytes, status normal
  localparam tpfr_pkg::out_item_t ResetPad = '{link_status: tpfr_pkg::LS_NORMAL,
                                               frame_done: 1'b0,
                                               dpad_x_code: 2'd3, dpad_y_code: 2'd3,
                                               default: '0};

  // Reset limits: error bytes, success, idle restart, incomplete by attempts
  localparam feed_t DirectedStart [14] = '{
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b1, ResetPad},  // first tick after reset
    '{'{tpfr_pkg::ACT_BYTE, 8'h00, 1'b1}, 1'b1, ResetPad},  // error byte opens frame
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h3f, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h7f, 1'b1}, 1'b0, '0},        // error byte inside frame
    '{'{tpfr_pkg::ACT_BYTE, 8'h40, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'hbf, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'hff, 1'b0}, 1'b0, '0},        // all four slots: success
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},        // idle timer restarts
    '{'{tpfr_pkg::ACT_BYTE, 8'hc0, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h15, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h2a, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h3f, 1'b0}, 1'b0, '0}         // fifth attempt: incomplete
  };

  // Zero limits (act as one): idle timeout, byte wait timeout, one-attempt frames
  localparam feed_t DirectedLow [5] = '{
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h55, 1'b1}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h80, 1'b0}, 1'b0, '0}
  };

  // Largest limits: a slow frame that still completes
  localparam feed_t DirectedHigh [6] = '{
    '{'{tpfr_pkg::ACT_BYTE, 8'hff, 1'b1}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'he5, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h9a, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_TICK, 8'h00, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h6c, 1'b0}, 1'b0, '0},
    '{'{tpfr_pkg::ACT_BYTE, 8'h13, 1'b0}, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tpfr_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tpfr_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = '0;
  logic [15:0]         cfg_wdata = '0;

  tagged_pad_frame_receiver DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Pending stimulus and expected results
  feed_t               byte_tick_q [$];
  tpfr_pkg::out_item_t pad_results_q [$];
  feed_t               offered;
  int unsigned items_queued, items_taken, results_seen, mismatches;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned frames_ok, frames_short, idle_fails;

  // Frame state mirror
  logic [7:0]             slot_mirror [4];
  logic [3:0]             seen_tags;
  logic [3:0]             tries;
  int unsigned            wait_ticks, idle_ticks;
  logic                   framing, idle_live;
  tpfr_pkg::link_status_e status_m;
  logic [3:0]             try_limit;
  logic [15:0]            wait_limit, idle_limit;

  function automatic void reset_model();
    slot_mirror = '{8'h3f, 8'h7f, 8'h8f, 8'hc0};
    seen_tags   = '0;
    tries       = '0;
    wait_ticks  = 0;
    idle_ticks  = 0;
    framing     = 1'b0;
    idle_live   = 1'b0;
    status_m    = tpfr_pkg::LS_NORMAL;
    try_limit   = 4'd5;
    wait_limit  = 16'd10;
    idle_limit  = 16'd100;
  endfunction

  function automatic int unsigned tick_limit(logic [15:0] lim);
    return (lim == 0) ? 1 : lim;
  endfunction

  function automatic void close_frame(tpfr_pkg::link_status_e outcome);
    status_m   = outcome;
    framing    = 1'b0;
    seen_tags  = '0;
    tries      = '0;
    wait_ticks = 0;
    idle_live  = 1'b0;
    idle_ticks = 0;
    if (outcome == tpfr_pkg::LS_SUCCESS) frames_ok++;
    else frames_short++;
  endfunction

  // Uses one attempt; returns 1 when the frame ends as incomplete
  function automatic logic spend_attempt();
    int unsigned lim;
    lim = (try_limit == 0) ? 1 : try_limit;
    if (tries < 15) tries++;
    wait_ticks = 0;
    if (tries >= lim) begin
      close_frame(tpfr_pkg::LS_INCOMPLETE);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the mirror by one item and returns the result it should produce
  function automatic tpfr_pkg::out_item_t advance_frame(tpfr_pkg::in_item_t it);
    tpfr_pkg::out_item_t r;
    logic                done;
    logic [1:0]          tag;
    done = 1'b0;
    if (it.action == tpfr_pkg::ACT_BYTE) begin
      if (!framing) begin
        framing    = 1'b1;
        seen_tags  = '0;
        tries      = '0;
        wait_ticks = 0;
        idle_live  = 1'b0;
        idle_ticks = 0;
      end
      if (!it.rx_error) begin
        tag              = it.rx_byte[7:6];
        slot_mirror[tag] = it.rx_byte;
        seen_tags[tag]   = 1'b1;
        if (seen_tags == 4'hf) begin
          close_frame(tpfr_pkg::LS_SUCCESS);
          done = 1'b1;
        end else begin
          done = spend_attempt();
        end
      end
    end else if (framing) begin
      if (wait_ticks < TimerMax) wait_ticks++;
      if (wait_ticks >= tick_limit(wait_limit)) done = spend_attempt();
    end else begin
      // the tick that starts the idle timer is its first count
      if (!idle_live) begin
        idle_live  = 1'b1;
        idle_ticks = 0;
        status_m   = tpfr_pkg::LS_NORMAL;
      end
      if (idle_ticks < TimerMax) idle_ticks++;
      if (idle_ticks >= tick_limit(idle_limit)) begin
        status_m   = tpfr_pkg::LS_FAILURE;
        idle_live  = 1'b0;
        idle_ticks = 0;
        idle_fails++;
      end
    end
    r.link_status        = status_m;
    r.frame_done         = done;
    r.dpad_x_code        = {slot_mirror[0][5], slot_mirror[1][1]};
    r.dpad_y_code        = {slot_mirror[0][4], slot_mirror[1][0]};
    r.right_stick_x_code = slot_mirror[2][5:4];
    r.right_stick_y_code = slot_mirror[3][1:0];
    r.left_stick_x_code  = slot_mirror[3][3:2];
    r.left_stick_y_code  = slot_mirror[3][5:4];
    r.misc_buttons       = ~slot_mirror[0][3:0];
    r.shoulder_buttons   = ~slot_mirror[1][5:2];
    r.mark_buttons       = ~slot_mirror[2][3:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(tpfr_pkg::out_item_t want,
                                         tpfr_pkg::out_item_t got);
    check_field("link_status", want.link_status, got.link_status);
    check_field("frame_done", want.frame_done, got.frame_done);
    check_field("dpad_x_code", want.dpad_x_code, got.dpad_x_code);
    check_field("dpad_y_code", want.dpad_y_code, got.dpad_y_code);
    check_field("right_stick_x_code", want.right_stick_x_code, got.right_stick_x_code);
    check_field("right_stick_y_code", want.right_stick_y_code, got.right_stick_y_code);
    check_field("left_stick_x_code", want.left_stick_x_code, got.left_stick_x_code);
    check_field("left_stick_y_code", want.left_stick_y_code, got.left_stick_y_code);
    check_field("misc_buttons", want.misc_buttons, got.misc_buttons);
    check_field("shoulder_buttons", want.shoulder_buttons, got.shoulder_buttons);
    check_field("mark_buttons", want.mark_buttons, got.mark_buttons);
  endfunction

  function automatic void queue_item(logic action, logic [7:0] data, logic err);
    feed_t f;
    f.item  = '{action, data, err};
    f.typed = 1'b0;
    f.want  = '0;
    byte_tick_q.push_back(f);
    items_queued++;
  endfunction

  // Random stream: mostly whole frames in shuffled slot order, plus tick runs and noise
  task automatic queue_random(int unsigned count);
    logic [1:0]  order [4];
    logic [1:0]  swap_tag;
    int unsigned goal, kind, pick, gaps;
    goal = items_queued + count;
    while (items_queued < goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        order = '{2'd0, 2'd1, 2'd2, 2'd3};
        for (int i = 3; i > 0; i--) begin
          pick        = $urandom_range(0, i);
          swap_tag    = order[i];
          order[i]    = order[pick];
          order[pick] = swap_tag;
        end
        foreach (order[i]) begin
          gaps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
          repeat (gaps) queue_item(tpfr_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
          if ($urandom_range(0, 7) == 0) begin
            queue_item(tpfr_pkg::ACT_BYTE, 8'($urandom), 1'b1);
          end
          if ($urandom_range(0, 9) == 0) begin
            queue_item(tpfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
          end
          queue_item(tpfr_pkg::ACT_BYTE, {order[i], 6'($urandom)}, 1'b0);
        end
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 24)) begin
          queue_item(tpfr_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_item(1'($urandom), 8'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tpfr_pkg::CFG_ATTEMPT_LIMIT: try_limit  = data[3:0];
      tpfr_pkg::CFG_BYTE_WAIT:     wait_limit = data;
      tpfr_pkg::CFG_IDLE_TIMEOUT:  idle_limit = data;
      default: ;
    endcase
  endtask

  // Upper bits of the attempt register write are junk; the unused index must do nothing
  task automatic set_limits(int unsigned attempts, int unsigned wait_lim, int unsigned idle_lim);
    write_cfg(tpfr_pkg::CFG_ATTEMPT_LIMIT, {12'($urandom), 4'(attempts)});
    write_cfg(tpfr_pkg::CFG_BYTE_WAIT, 16'(wait_lim));
    write_cfg(tpfr_pkg::CFG_IDLE_TIMEOUT, 16'(idle_lim));
    write_cfg(CfgIdxUnused, 16'($urandom));
  endtask

  // Waits until every queued item went in and every result came out
  task automatic drain();
    do @(negedge clk);
    while (byte_tick_q.size() != 0 || in_valid || pad_results_q.size() != 0);
  endtask

  // Sender: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    logic                accepted;
    tpfr_pkg::out_item_t predicted;
    if (rst_n) begin
      accepted = in_valid && !in_stall;
      if (accepted) begin
        predicted = advance_frame(offered.item);
        pad_results_q.push_back(offered.typed ? offered.want : predicted);
        items_taken++;
      end
      if (!in_valid || accepted) begin
        if (byte_tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = byte_tick_q.pop_front();
          in_item  <= offered.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result, stalls at random, holds off once for a long stretch
  always @(posedge clk) begin
    int unsigned hold_left;
    logic        hold_done;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pad_results_q.size() == 0) begin
          $error("result arrived with no item pending");
          mismatches++;
        end else begin
          compare_result(pad_results_q.pop_front(), out_item);
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end else begin
      hold_left = 0;
      hold_done = 1'b0;
    end
  end

  initial begin
    reset_model();
    send_idle_pct  = 25;
    recv_stall_pct = 46;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DirectedStart[i]) byte_tick_q.push_back(DirectedStart[i]);
    drain();
    set_limits(0, 0, 0);
    foreach (DirectedLow[i]) byte_tick_q.push_back(DirectedLow[i]);
    drain();
    set_limits(15, 16'hffff, 16'hffff);
    foreach (DirectedHigh[i]) byte_tick_q.push_back(DirectedHigh[i]);
    drain();

    // Random phases: idling pattern changes every third phase
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct  = 25;
        recv_stall_pct = 46;
      end else if (p < 6) begin
        send_idle_pct  = 46;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: set_limits(4, 3, 5);
        1: set_limits(15, 1, 1);
        2: set_limits(1, 2, 8);
        3: set_limits(6, 16'hffff, 16'hffff);
        8: set_limits(5, 10, 100);
        default: set_limits($urandom_range(0, 15), $urandom_range(0, 12),
                            $urandom_range(0, 30));
      endcase
      queue_random(100);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d results for %0d items over 12 limit settings.",
             results_seen, items_taken);
    $display("Frames complete %0d, incomplete %0d, idle timeouts %0d.",
             frames_ok, frames_short, idle_fails);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
